>>> hw/rtl/fld_pkg.sv
// ----------------------------------------------------------------------------
// fld_pkg
// Shared types and constants of the fixed-length packet deframer.
// ----------------------------------------------------------------------------
package fld_pkg;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int IDX_W   = 4;
  localparam int CFG_A_W = 2;

  // default store depth
  localparam int MAX_PAYLOAD_DEF = 16;

  // register reset values
  localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hA5;
  localparam logic [BYTE_W-1:0] TRAILER_RST = 8'h5A;
  localparam logic [LEN_W-1:0]  LENGTH_RST  = 5'd11;

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_HEADER  = 2'd0,
    CFG_TRAILER = 2'd1,
    CFG_LENGTH  = 2'd2
  } cfg_index_t;

  // deframer phases
  typedef enum logic [1:0] {
    ST_HUNT    = 2'd0,
    ST_COLLECT = 2'd1,
    ST_WAIT    = 2'd2,
    ST_DRAIN   = 2'd3
  } fld_state_t;

  // read request from the control to the output stage
  typedef struct packed {
    logic             issue;
    logic [IDX_W-1:0] index;
    logic             last;
  } rd_meta_t;

endpackage

>>> hw/rtl/fld_if.sv
// ----------------------------------------------------------------------------
// fld_if
// Valid/ready channels for received bytes and for payload results.
// ----------------------------------------------------------------------------
interface fld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface fld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [3:0] payload_index;
  logic       last;

  modport source (output valid, output payload_byte, output payload_index, output last,
                  input ready);
  modport sink (input valid, input payload_byte, input payload_index, input last,
                output ready);
endinterface

>>> hw/rtl/fld_mem.sv
// ----------------------------------------------------------------------------
// fld_mem
// Payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fld_mem #(
  parameter int DEPTH  = fld_pkg::MAX_PAYLOAD_DEF,
  parameter int ADDR_W = 4
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [fld_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [fld_pkg::BYTE_W-1:0] rd_data
);
  import fld_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/fld_ctrl.sv
// ----------------------------------------------------------------------------
// fld_ctrl
// Header hunt, payload collection, trailer wait and store read sequencing.
// ----------------------------------------------------------------------------
module fld_ctrl #(
  parameter int MAX_PAYLOAD = fld_pkg::MAX_PAYLOAD_DEF,
  parameter int ADDR_W      = 4,
  parameter int CNT_W       = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [fld_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [fld_pkg::BYTE_W-1:0]  cfg_wdata,
  // received bytes
  fld_in_if.sink                      in_chan,
  // store ports
  output logic                        mem_we,
  output logic [ADDR_W-1:0]           mem_waddr,
  output logic [fld_pkg::BYTE_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [ADDR_W-1:0]           mem_raddr,
  // output stage
  output fld_pkg::rd_meta_t           rd_meta,
  input  logic                        slot_free
);
  import fld_pkg::*;

  localparam int LW = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [LW-1:0]    MAX_L = LW'(MAX_PAYLOAD);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_PAYLOAD);

  fld_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [BYTE_W-1:0] header_r, trailer_r;
  logic [LEN_W-1:0]  length_r;

  logic              accept;
  logic              issue;
  logic              count_full;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  count_new;
  logic [CNT_W-1:0]  rd_idx_inc;
  logic [LW-1:0]     len_l;
  logic [LW-1:0]     eff_len;
  logic              collect_done;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RST;
      trailer_r <= TRAILER_RST;
      length_r  <= LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER:  header_r  <= cfg_wdata;
        CFG_TRAILER: trailer_r <= cfg_wdata;
        CFG_LENGTH:  length_r  <= cfg_wdata[LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  // effective length: zero means one, clamp to store depth
  always_comb begin
    len_l = LW'(length_r);
    if (length_r == '0) begin
      eff_len = LW'(1);
    end else if (len_l > MAX_L) begin
      eff_len = MAX_L;
    end else begin
      eff_len = len_l;
    end
  end

  assign count_full   = (count_r == MAX_C);
  assign count_inc    = count_r + CNT_W'(1);
  assign count_new    = count_full ? count_r : count_inc;
  assign collect_done = (LW'(count_new) >= eff_len);
  assign rd_idx_inc   = rd_idx_r + CNT_W'(1);
  assign accept       = in_chan.valid && in_chan.ready;
  assign issue        = (state_r == ST_DRAIN) && slot_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: begin
        if (accept && in_chan.rx_byte == header_r) begin
          state_nxt = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (accept && collect_done) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (accept && in_chan.rx_byte == trailer_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (issue && rd_idx_inc == count_r) begin
          state_nxt = ST_HUNT;
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  // outputs: input stall during drain keeps writes and reads apart
  always_comb begin
    in_chan.ready = (state_r != ST_DRAIN);
    mem_we        = accept && (state_r == ST_COLLECT) && !count_full;
    mem_waddr     = count_r[ADDR_W-1:0];
    mem_wdata     = in_chan.rx_byte;
    mem_re        = issue;
    mem_raddr     = rd_idx_r[ADDR_W-1:0];
    rd_meta.issue = issue;
    rd_meta.index = IDX_W'(rd_idx_r);
    rd_meta.last  = (rd_idx_inc == count_r);
  end

  // byte count and read index
  always_comb begin
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    if (accept && state_r == ST_HUNT && in_chan.rx_byte == header_r) begin
      count_nxt = '0;
    end
    if (accept && state_r == ST_COLLECT) begin
      count_nxt = count_new;
    end
    if (accept && state_r == ST_WAIT) begin
      rd_idx_nxt = '0;
    end
    if (issue) begin
      rd_idx_nxt = rd_idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT;
      count_r  <= '0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

endmodule

>>> hw/rtl/fld_out.sv
// ----------------------------------------------------------------------------
// fld_out
// Output stage: tracks the read in flight and holds the result request.
// ----------------------------------------------------------------------------
module fld_out (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fld_pkg::rd_meta_t          rd_meta,
  input  logic [fld_pkg::BYTE_W-1:0] rd_data,
  output logic                       slot_free,
  fld_out_if.source                  out_chan
);
  import fld_pkg::*;

  logic              pending_r;
  logic [IDX_W-1:0]  pend_index_r;
  logic              pend_last_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [IDX_W-1:0]  out_index_r;
  logic              out_last_r;

  // a new read may start when nothing is in flight and the slot empties
  assign slot_free = !pending_r && (!out_valid_r || out_chan.ready);

  // read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else begin
      pending_r <= rd_meta.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_meta.issue) begin
      pend_index_r <= rd_meta.index;
      pend_last_r  <= rd_meta.last;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pending_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pending_r) begin
      out_byte_r  <= rd_data;
      out_index_r <= pend_index_r;
      out_last_r  <= pend_last_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.payload_byte  = out_byte_r;
  assign out_chan.payload_index = out_index_r;
  assign out_chan.last          = out_last_r;

endmodule

>>> hw/rtl/fixed_length_packet_deframer.sv
// The first payload request passes the drain state, the store read register
// and the result register after the trailer is accepted. Throughput: one
// received byte per cycle outside a drain, where input is stalled; a drain
// reads a new request only with no read in flight and a free output slot.
// Synchronous active-low reset returns to header hunt and restores register
// defaults; store contents are not cleared.
// ----------------------------------------------------------------------------
// fixed_length_packet_deframer
// Top level: hunts a header, stores a fixed-length payload, releases it on
// the trailer as a run of requests with the final one marked.
// ----------------------------------------------------------------------------
module fixed_length_packet_deframer #(
  parameter int MAX_PAYLOAD = fld_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fld_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [fld_pkg::BYTE_W-1:0]  cfg_wdata,
  fld_in_if.sink                      in_chan,
  fld_out_if.source                   out_chan
);
  import fld_pkg::*;

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;
  rd_meta_t          rd_meta;
  logic              slot_free;

  // control sequencer
  fld_ctrl #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .ADDR_W      (ADDR_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .rd_meta   (rd_meta),
    .slot_free (slot_free)
  );

  // payload store
  fld_mem #(
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // output stage
  fld_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_meta   (rd_meta),
    .rd_data   (mem_rdata),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );

endmodule

>>> hw/rtl/fld_checker.sv
// ----------------------------------------------------------------------------
// fld_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module fld_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic [3:0] out_payload_index,
  input logic       out_last
);
  import fld_pkg::*;

  logic [IDX_W-1:0] exp_idx_r;
  logic             out_acc;

  assign out_acc = out_valid && out_ready;

  // expected index of the next delivered request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_idx_r <= '0;
    end else if (out_acc) begin
      exp_idx_r <= out_last ? '0 : exp_idx_r + IDX_W'(1);
    end
  end

  // payload indexes count up from zero and restart after the last byte
  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> out_payload_index == exp_idx_r)
    else $error("payload index out of sequence");

  // nothing is offered in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled request stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a stalled request keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_payload_byte) && $stable(out_payload_index)
      && $stable(out_last))
    else $error("result changed while stalled");

endmodule

bind fixed_length_packet_deframer fld_checker u_fld_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_payload_byte  (out_chan.payload_byte),
  .out_payload_index (out_chan.payload_index),
  .out_last          (out_chan.last)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the fixed-length packet deframer. Received bytes are driven
// in random bursts. The scoreboard follows the deframer's hunt, collect and
// wait behavior and the register settings. It predicts every payload request
// released by a trailer and checks each request, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fld_pkg::*;

  // index that no register answers to
  localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;
  localparam int STORE_DEPTH = MAX_PAYLOAD_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  // one payload request as seen on the result channel
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  index;
    logic              last;
  } payload_beat_t;

  typedef enum int {
    RCV_OPEN,
    RCV_RANDOM,
    RCV_CHOKE
  } rcv_mode_t;

  // --------------------------------------------------------------------------
  // deframe predictor and request checker
  // --------------------------------------------------------------------------
  class payload_scoreboard;
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] trailer;
    logic [LEN_W-1:0]  length;
    fld_state_t        phase;
    int unsigned       count;
    logic [BYTE_W-1:0] store [STORE_DEPTH];
    payload_beat_t     pending [$];
    int                errors;

    function new();
      header  = HEADER_RST;
      trailer = TRAILER_RST;
      length  = LENGTH_RST;
      phase   = ST_HUNT;
      count   = 0;
      errors  = 0;
    endfunction

    // length in force: zero counts as one, large values clip to the store
    function int unsigned eff_length();
      int unsigned n;
      n = length;
      if (n == 0) n = 1;
      if (n > STORE_DEPTH) n = STORE_DEPTH;
      return n;
    endfunction

    // register update, unknown indexes are dropped
    function void write_reg(logic [CFG_A_W-1:0] idx, logic [BYTE_W-1:0] val);
      case (idx)
        CFG_HEADER:  header = val;
        CFG_TRAILER: trailer = val;
        CFG_LENGTH:  length = val[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // advance on one accepted byte, queue the payload released by a trailer
    function void note_request(logic [BYTE_W-1:0] b);
      payload_beat_t beat;
      case (phase)
        ST_COLLECT: begin
          if (count < STORE_DEPTH) begin
            store[count] = b;
            count++;
          end
          if (count >= eff_length()) phase = ST_WAIT;
        end
        ST_WAIT: begin
          // anything but the trailer is skipped, header included
          if (b == trailer) begin
            for (int unsigned k = 0; k < count; k++) begin
              beat.data  = store[k];
              beat.index = IDX_W'(k);
              beat.last  = (k + 1 == count);
              pending.push_back(beat);
            end
            phase = ST_HUNT;
          end
        end
        default: begin
          phase = ST_HUNT;
          if (b == header) begin
            phase = ST_COLLECT;
            count = 0;
          end
        end
      endcase
    endfunction

    function void report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endfunction

    // compare one payload request with the oldest one predicted
    function void check_result(payload_beat_t got);
      payload_beat_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected request byte %02h index %0d last %0b",
                         got.data, got.index, got.last));
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data)
        report($sformatf("payload_byte %02h, predicted %02h", got.data, want.data));
      if (got.index !== want.index)
        report($sformatf("payload_index %0d, predicted %0d", got.index, want.index));
      if (got.last !== want.last)
        report($sformatf("last %0b, predicted %0b at index %0d",
                         got.last, want.last, want.index));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_A_W-1:0] cfg_index;
  logic [BYTE_W-1:0]  cfg_wdata;

  fld_in_if  in_ch ();
  fld_out_if out_ch ();

  payload_scoreboard sb = new();

  int unsigned burst_left = 1;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned rcv_left = 0;
  rcv_mode_t   rcv_mode = RCV_OPEN;

  fixed_length_packet_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_ch),
    .out_chan  (out_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side stalls in stretches of its own
  always @(negedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode = rcv_mode_t'($urandom_range(0, 2));
      rcv_left = $urandom_range(4, 40);
    end
    rcv_left--;
    case (rcv_mode)
      RCV_OPEN:   out_ch.ready <= 1'b1;
      RCV_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
      default:    out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // check every accepted payload request
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.payload_byte, out_ch.payload_index, out_ch.last});
  end

  // watchdog on cycles without any accepted byte or payload request
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // drive one byte, then keep the burst going or open a gap
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(b);
    sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // stop sending until all predicted requests are out, then let the block rest
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // well-formed packet with stray bytes around it
  task automatic send_frame();
    logic [BYTE_W-1:0] v;
    int unsigned n;
    n = $urandom_range(0, 2);
    repeat (n) begin
      v = 8'($urandom);
      if (v == sb.header) v ^= 8'h01;
      send_byte(v);
    end
    send_byte(sb.header);
    n = sb.eff_length();
    // payload may hold the header and trailer values too
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       v = sb.header;
        1:       v = sb.trailer;
        default: v = 8'($urandom);
      endcase
      send_byte(v);
    end
    n = $urandom_range(0, 2);
    repeat (n) begin
      v = ($urandom_range(0, 2) == 0) ? sb.header : 8'($urandom);
      if (v == sb.trailer) v ^= 8'h01;
      send_byte(v);
    end
    send_byte(sb.trailer);
  endtask

  // broken sequence: random bytes or a packet cut short
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 5);
    if ($urandom_range(0, 1) == 0) send_byte(sb.header);
    repeat (n) send_byte(8'($urandom));
  endtask

  initial begin
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] trl;
    logic [BYTE_W-1:0] len;
    int unsigned start;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_HEADER;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extreme byte values, zero length, unused index, skipped bytes
    write_reg(CFG_HEADER, 8'h00);
    write_reg(CFG_TRAILER, 8'hFF);
    write_reg(CFG_LENGTH, 8'h00);
    write_reg(CFG_UNUSED, 8'h07);
    send_byte(8'h12);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h33);
    send_byte(8'hFF);

    // length shrinks under a partly collected packet
    settle();
    write_reg(CFG_HEADER, 8'hFF);
    write_reg(CFG_TRAILER, 8'h00);
    write_reg(CFG_LENGTH, 8'd4);
    send_byte(8'hFF);
    send_byte(8'hAA);
    send_byte(8'h55);
    settle();
    write_reg(CFG_LENGTH, 8'd1);
    send_byte(8'h80);
    send_byte(8'h00);

    // length grows under a partly collected packet
    settle();
    write_reg(CFG_LENGTH, 8'd2);
    send_byte(8'hFF);
    send_byte(8'h01);
    settle();
    write_reg(CFG_LENGTH, 8'd3);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h00);

    // random packets under several register settings
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      hdr = 8'($urandom);
      trl = 8'($urandom);
      len = 8'($urandom_range(1, 8));
      case (ph)
        0: begin
          hdr = 8'hFF;
          trl = 8'h00;
          len = 8'd31;
        end
        1: begin
          hdr = 8'h00;
          trl = 8'hFF;
          len = 8'd1;
        end
        2: len = 8'd0;
        3: len = 8'd16;
        default: ;
      endcase
      write_reg(CFG_HEADER, hdr);
      write_reg(CFG_TRAILER, trl);
      write_reg(CFG_LENGTH, len);
      start = sent;
      while (sent - start < 10) begin
        if ($urandom_range(0, 4) != 0)
          send_frame();
        else
          send_noise();
        if ($urandom_range(0, 14) == 0) settle();
      end
    end

    // drain and let the block go quiet
    settle();
    repeat (12) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
